@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/core/hclru_pkg.sv @@
`default_nettype none

package hclru_pkg;

  localparam int DEF_NUM_SETS   = 2048;
  localparam int DEF_NUM_WAYS   = 16;
  localparam int DEF_COUNT_BITS = 8;

  localparam int KIND_W    = 2;
  localparam int SET_IDX_W = 11;
  localparam int WAY_IDX_W = 4;
  localparam int THR_W     = 8;

  localparam logic [THR_W-1:0] THR_RESET = 8'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_VICTIM = 2'd0,
    KIND_HIT    = 2'd1,
    KIND_FILL   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/hot_cold_lru_replacement_core.sv @@
`default_nettype none

// channel   dir  handshake                  payload
// request   in   in_valid / in_ready        kind, set_index, way_index
// victim    out  out_valid / out_ready      victim_way
// config    in   cfg_write_en               cold_threshold
//
// each request is taken in idle: the set row is read from the row memory on
// the accept edge and, for a hit or fill to a valid way, modified and written
// back from the busy state; no new request is taken until it returns to idle.
// after reset the row memory is swept to its reset value, one row per cycle,
// through all NUM_SETS rows (2048 by default) with in_ready low; config writes are taken.
// a victim result stalled at the output holds the core in its busy state.

module hot_cold_lru_replacement_core #(
  parameter int NUM_SETS   = hclru_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS   = hclru_pkg::DEF_NUM_WAYS,
  parameter int COUNT_BITS = hclru_pkg::DEF_COUNT_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [hclru_pkg::KIND_W-1:0]     kind,
  input  wire logic [hclru_pkg::SET_IDX_W-1:0]  set_index,
  input  wire logic [hclru_pkg::WAY_IDX_W-1:0]  way_index,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [hclru_pkg::WAY_IDX_W-1:0]       victim_way,
  input  wire logic                             cfg_write_en,
  input  wire logic [hclru_pkg::THR_W-1:0]      cold_threshold
);

  import hclru_pkg::*;

  `include "assert_macros.svh"

  localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int RANK_W   = $clog2(NUM_WAYS);
  localparam int RANK_TOT = NUM_WAYS * RANK_W;
  localparam int ROW_W    = RANK_TOT + NUM_WAYS * COUNT_BITS;
  localparam int CMP_W    = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

  state_t state, state_next;

  logic [THR_W-1:0]      thr;
  logic [SET_W-1:0]      clr_idx;
  logic [SET_W-1:0]      set_mod;
  kind_t                 q_kind;
  logic                  q_upd;
  logic [SET_W-1:0]      q_set;
  logic [RANK_W-1:0]     q_way;
  logic [ROW_W-1:0]      rd_row;
  logic [ROW_W-1:0]      upd_row;
  logic [ROW_W-1:0]      reset_row;
  logic [ROW_W-1:0]      mem_wdata;
  logic [SET_W-1:0]      mem_waddr;
  logic                  mem_we;
  logic                  accept;
  logic                  way_ok;
  logic                  out_load;
  logic [RANK_W-1:0]     old_rank;
  logic [COUNT_BITS-1:0] old_cnt;
  logic [RANK_W-1:0]     cold_way;
  logic                  cold_any;
  logic [RANK_W-1:0]     lru_way;
  logic [RANK_W-1:0]     victim_sel;

  logic [ROW_W-1:0] mem [NUM_SETS];

  // set index reduced modulo NUM_SETS
  generate
    if (NUM_SETS == 1) begin : g_mod_one
      assign set_mod = '0;
    end else if (NUM_SETS >= (1 << SET_IDX_W)) begin : g_mod_none
      assign set_mod = SET_W'(set_index);
    end else if ((NUM_SETS & (NUM_SETS - 1)) == 0) begin : g_mod_mask
      assign set_mod = set_index[SET_W-1:0];
    end else begin : g_mod_recip
      localparam int     MOD_K     = SET_IDX_W + $clog2(NUM_SETS);
      localparam longint MOD_RECIP = ((longint'(1) << MOD_K) + NUM_SETS - 1) / NUM_SETS;
      logic [31:0] prod;
      logic [31:0] quo;
      logic [31:0] rem;
      always_comb begin
        prod = 32'(set_index) * 32'(MOD_RECIP);
        quo  = prod >> MOD_K;
        rem  = 32'(set_index) - quo * 32'(NUM_SETS);
      end
      assign set_mod = SET_W'(rem);
    end
  endgenerate

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign way_ok   = (32'(way_index) < 32'(NUM_WAYS));

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_write_en) begin
      thr <= cold_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_kind <= kind_t'(kind);
      q_upd  <= way_ok && (kind_t'(kind) == KIND_HIT || kind_t'(kind) == KIND_FILL);
      q_set  <= set_mod;
      q_way  <= RANK_W'(way_index);
    end
  end

  // row memory: one read port used on accept, one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_row <= mem[set_mod];
    end
  end

  always_comb begin
    reset_row = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      reset_row[i*RANK_W +: RANK_W] = RANK_W'(i);
    end
  end

  // row update: move q_way to rank 0, age the ways ahead of it, adjust its count
  always_comb begin
    logic [RANK_W-1:0] r;
    old_rank = rd_row[q_way*RANK_W +: RANK_W];
    old_cnt  = rd_row[RANK_TOT + q_way*COUNT_BITS +: COUNT_BITS];
    upd_row  = rd_row;
    for (int i = 0; i < NUM_WAYS; i++) begin
      r = rd_row[i*RANK_W +: RANK_W];
      if (RANK_W'(i) == q_way) begin
        upd_row[i*RANK_W +: RANK_W] = '0;
      end else if (r < old_rank) begin
        upd_row[i*RANK_W +: RANK_W] = r + RANK_W'(1);
      end
    end
    if (q_kind == KIND_HIT) begin
      if (old_cnt != '1) begin
        upd_row[RANK_TOT + q_way*COUNT_BITS +: COUNT_BITS] = old_cnt + COUNT_BITS'(1);
      end
    end else if (old_cnt != '0) begin
      upd_row[RANK_TOT + q_way*COUNT_BITS +: COUNT_BITS] = old_cnt - COUNT_BITS'(1);
    end
  end

  // victim: lowest cold way, else the way at the oldest rank
  always_comb begin
    cold_way = '0;
    cold_any = 1'b0;
    lru_way  = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (CMP_W'(rd_row[RANK_TOT + i*COUNT_BITS +: COUNT_BITS]) <= CMP_W'(thr)) begin
        cold_way = RANK_W'(i);
        cold_any = 1'b1;
      end
      if (rd_row[i*RANK_W +: RANK_W] == RANK_W'(NUM_WAYS - 1)) begin
        lru_way = RANK_W'(i);
      end
    end
    victim_sel = cold_any ? cold_way : lru_way;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + SET_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = q_set;
    mem_wdata  = upd_row;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = reset_row;
        if (clr_idx == SET_W'(NUM_SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (q_kind == KIND_VICTIM) begin
          // wait here while the previous victim beat is not taken
          if (!out_valid || out_ready) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          mem_we     = q_upd;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      victim_way <= WAY_IDX_W'(victim_sel);
    end
  end

  `ASSERT_ALWAYS(a_one_per_two, clk, rst, (in_valid && in_ready) |=> !in_ready,
    "request accepted in back-to-back cycles")
  `ASSERT_NEVER(a_query_no_write, clk, rst, mem_we && state == ST_BUSY && q_kind == KIND_VICTIM,
    "victim query wrote the row memory")
  `ASSERT_ALWAYS(a_out_from_query, clk, rst,
    $rose(out_valid) |-> ($past(state) == ST_BUSY && $past(q_kind) == KIND_VICTIM),
    "victim beat without a victim query")
  `ASSERT_ALWAYS(a_clear_no_accept, clk, rst,
    (state == ST_CLEAR && clr_idx != SET_W'(NUM_SETS - 1)) |=> !in_ready,
    "request taken during row clear")

endmodule

`default_nettype wire
